>>> hw/rtl/rcfr_pkg.sv
// shared types and constants for the relay controller with frame receiver
`default_nettype none

package rcfr_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_SAMPLE  = 3'd0;
  localparam logic [2:0] OP_BYTE    = 3'd1;
  localparam logic [2:0] OP_MODE    = 3'd2;
  localparam logic [2:0] OP_TOGGLE1 = 3'd3;
  localparam logic [2:0] OP_TOGGLE2 = 3'd4;

  // frame status codes
  localparam logic [1:0] FS_NONE    = 2'd0;
  localparam logic [1:0] FS_APPLIED = 2'd1;
  localparam logic [1:0] FS_IGNORED = 2'd2;
  localparam logic [1:0] FS_BAD     = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_ON    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAS_OFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_ON  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_OFF = 2'd3;

  // field widths
  localparam int unsigned LEVEL_W = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 5;

  // threshold reset values
  localparam logic [LEVEL_W-1:0] ON_LEVEL_RST  = 12'd2500;
  localparam logic [LEVEL_W-1:0] OFF_LEVEL_RST = 12'd2300;

  // frame layout
  localparam logic [BYTE_W-1:0] FRAME_START  = 8'hAA;
  localparam logic [BYTE_W-1:0] FRAME_END    = 8'h55;
  localparam logic [POS_W-1:0]  PAYLOAD_LAST = 5'd15;
  localparam logic [POS_W-1:0]  RELAY_POS    = 5'd14;
  localparam logic [POS_W-1:0]  CHECK_POS    = 5'd16;
  localparam logic [POS_W-1:0]  LAST_POS     = 5'd17;

  // frame receiver event towards the relay control
  typedef struct packed {
    logic       apply;
    logic [1:0] relays;
    logic [1:0] status;
  } frm_evt_t;

  // one result item
  typedef struct packed {
    logic       relay_one;
    logic       relay_two;
    logic       buzzer;
    logic       auto_active;
    logic [1:0] frame_status;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rcfr_frame_rx.sv
// serial command frame receiver: start detect, payload xor, end and checksum check
`default_nettype none

module rcfr_frame_rx
  import rcfr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              auto_i,
  output frm_evt_t               evt_o
);

  logic [POS_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [BYTE_W-1:0] chk_q, chk_d;
  logic              good;

  always_comb begin
    count_d = count_q;
    xor_d   = xor_q;
    cmd_d   = cmd_q;
    chk_d   = chk_q;
    good    = 1'b0;
    evt_o   = '{apply: 1'b0, relays: cmd_q, status: FS_NONE};
    if (byte_i == FRAME_START) begin
      // a start byte always reopens the frame
      count_d = POS_W'(1);
      xor_d   = '0;
    end else if (count_q != '0) begin
      if (count_q <= PAYLOAD_LAST) begin
        xor_d = xor_q ^ byte_i;
      end
      if (count_q == RELAY_POS) begin
        cmd_d = byte_i[1:0];
      end
      if (count_q == CHECK_POS) begin
        chk_d = byte_i;
      end
      if (count_q >= LAST_POS) begin
        count_d = '0;
        good    = (byte_i == FRAME_END) && (chk_d == xor_d);
        if (good) begin
          evt_o.status = auto_i ? FS_IGNORED : FS_APPLIED;
          evt_o.apply  = ~auto_i;
        end else begin
          evt_o.status = FS_BAD;
        end
        evt_o.relays = cmd_d;
      end else begin
        count_d = count_q + POS_W'(1);
      end
    end
    if (!take_i) begin
      evt_o = '{apply: 1'b0, relays: cmd_q, status: FS_NONE};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      xor_q   <= '0;
      cmd_q   <= '0;
      chk_q   <= '0;
    end else if (take_i) begin
      count_q <= count_d;
      xor_q   <= xor_d;
      cmd_q   <= cmd_d;
      chk_q   <= chk_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rcfr_ctrl.sv
// relay, buzzer and mode state with hysteresis control
`default_nettype none

module rcfr_ctrl
  import rcfr_pkg::*;
#(
  parameter int unsigned LVL_W = 12
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [OP_W-1:0]  op_i,
  input  wire logic [LVL_W-1:0] gas_i,
  input  wire logic [LVL_W-1:0] light_i,
  input  wire logic [LVL_W-1:0] gas_on_i,
  input  wire logic [LVL_W-1:0] gas_off_i,
  input  wire logic [LVL_W-1:0] light_on_i,
  input  wire logic [LVL_W-1:0] light_off_i,
  input  frm_evt_t              evt_i,
  output logic                  auto_o,
  output res_t                  res_o
);

  logic             alarm_q, alarm_d;
  logic             r1_q, r1_d;
  logic             r2_q, r2_d;
  logic             auto_q, auto_d;
  logic [LVL_W-1:0] gas_q, gas_d;
  logic [LVL_W-1:0] light_q, light_d;

  always_comb begin
    alarm_d = alarm_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    auto_d  = auto_q;
    gas_d   = gas_q;
    light_d = light_q;
    case (op_i)
      OP_SAMPLE: begin
        gas_d   = gas_i;
        light_d = light_i;
      end
      OP_BYTE: begin
        if (evt_i.apply) begin
          r1_d = evt_i.relays[0];
          r2_d = evt_i.relays[1];
        end
      end
      OP_MODE: begin
        auto_d = ~auto_q;
      end
      OP_TOGGLE1: begin
        if (!auto_q) begin
          r1_d = ~r1_q;
        end
      end
      OP_TOGGLE2: begin
        if (!auto_q) begin
          r2_d = ~r2_q;
        end
      end
      default: begin
      end
    endcase
    // control rule on the latest samples, on test first
    if (gas_d >= gas_on_i) begin
      alarm_d = 1'b1;
    end else if (gas_d <= gas_off_i) begin
      alarm_d = 1'b0;
    end
    if (auto_d) begin
      r1_d = alarm_d;
      if (light_d >= light_on_i) begin
        r2_d = 1'b1;
      end else if (light_d <= light_off_i) begin
        r2_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      r1_q    <= 1'b0;
      r2_q    <= 1'b0;
      auto_q  <= 1'b1;
      gas_q   <= '0;
      light_q <= '0;
    end else if (step_i) begin
      alarm_q <= alarm_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
      auto_q  <= auto_d;
      gas_q   <= gas_d;
      light_q <= light_d;
    end
  end

  assign auto_o = auto_q;

  always_comb begin
    res_o.relay_one    = r1_d;
    res_o.relay_two    = r2_d;
    res_o.buzzer       = alarm_d;
    res_o.auto_active  = auto_d;
    res_o.frame_status = evt_i.status;
  end

endmodule

`default_nettype wire

>>> hw/rtl/relay_controller_with_frame_rx_core.sv
// Top level of the relay controller with serial command frame receiver.
// Input channel (in_valid_i / in_stall_o) carries one event per transaction:
// a gas and light sample, a received serial byte, a mode toggle or a manual
// relay toggle. Every accepted transaction gives exactly one result on the
// output channel (out_valid_o / out_stall_i): both relay drives, the buzzer,
// the auto mode flag and the frame status of that event.
// The event waits in the input register, and the control and frame logic run
// between that register and the result register. One transaction per cycle
// is sustained while out_stall_i is low; the result register lets a new
// event be taken while a finished result waits.
// When the receiver stalls, the result register holds its payload, the input
// register fills, and in_stall_o rises until the result is taken.
// Thresholds are to be written through cfg_valid_i / cfg_ready_o while idle;
// the block does not enforce this, and the port is always ready. Reset clears both registers' valid flags, closes
// any open frame, clears relays and alarm, selects auto mode and loads the
// default thresholds.
`default_nettype none

module relay_controller_with_frame_rx_core
  import rcfr_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OP_W-1:0]      op_i,
  input  wire logic [LEVEL_W-1:0]   gas_level_i,
  input  wire logic [LEVEL_W-1:0]   light_level_i,
  input  wire logic [BYTE_W-1:0]    rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      relay_one_o,
  output logic                      relay_two_o,
  output logic                      buzzer_o,
  output logic                      auto_active_o,
  output logic [1:0]                frame_status_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [LEVEL_W-1:0]   cfg_data_i
);

  // readings keep only their low ADC_BITS bits, at most LEVEL_W
  localparam int unsigned LvlW = (ADC_BITS < LEVEL_W) ? ADC_BITS : LEVEL_W;
  localparam logic [LvlW-1:0] OnRst  = ON_LEVEL_RST[LvlW-1:0];
  localparam logic [LvlW-1:0] OffRst = OFF_LEVEL_RST[LvlW-1:0];

  logic              in_valid_q, in_valid_d;
  logic [OP_W-1:0]   op_q;
  logic [LvlW-1:0]   gas_q;
  logic [LvlW-1:0]   light_q;
  logic [BYTE_W-1:0] rx_q;
  logic              out_valid_q, out_valid_d;
  res_t              res_q;
  res_t              res_d;
  logic              adv;
  logic              accept;
  logic              auto_now;
  frm_evt_t          evt;

  logic [LvlW-1:0] gas_on_q, gas_off_q, light_on_q, light_off_q;

  assign adv         = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~adv;
  assign accept      = in_valid_i & ~in_stall_o;
  assign in_valid_d  = accept | (in_valid_q & ~adv);
  assign out_valid_d = adv | (out_valid_q & out_stall_i);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      gas_q   <= gas_level_i[LvlW-1:0];
      light_q <= light_level_i[LvlW-1:0];
      rx_q    <= rx_byte_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gas_on_q    <= OnRst;
      gas_off_q   <= OffRst;
      light_on_q  <= OnRst;
      light_off_q <= OffRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAS_ON:    gas_on_q    <= cfg_data_i[LvlW-1:0];
        REG_GAS_OFF:   gas_off_q   <= cfg_data_i[LvlW-1:0];
        REG_LIGHT_ON:  light_on_q  <= cfg_data_i[LvlW-1:0];
        REG_LIGHT_OFF: light_off_q <= cfg_data_i[LvlW-1:0];
        default: begin
        end
      endcase
    end
  end

  rcfr_frame_rx u_frame_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (adv && (op_q == OP_BYTE)),
    .byte_i (rx_q),
    .auto_i (auto_now),
    .evt_o  (evt)
  );

  rcfr_ctrl #(
    .LVL_W (LvlW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .op_i        (op_q),
    .gas_i       (gas_q),
    .light_i     (light_q),
    .gas_on_i    (gas_on_q),
    .gas_off_i   (gas_off_q),
    .light_on_i  (light_on_q),
    .light_off_i (light_off_q),
    .evt_i       (evt),
    .auto_o      (auto_now),
    .res_o       (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign relay_one_o    = res_q.relay_one;
  assign relay_two_o    = res_q.relay_two;
  assign buzzer_o       = res_q.buzzer;
  assign auto_active_o  = res_q.auto_active;
  assign frame_status_o = res_q.frame_status;

endmodule

`default_nettype wire

>>> hw/rtl/rcfr_checker.sv
// port-level checks for the relay controller core, bound to the top level
`default_nettype none

module rcfr_checker
  import rcfr_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       relay_one_o,
  input wire logic       relay_two_o,
  input wire logic       buzzer_o,
  input wire logic       auto_active_o,
  input wire logic [1:0] frame_status_o
);

  // a stalled result stays and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(relay_one_o)
      && $stable(relay_two_o) && $stable(buzzer_o) && $stable(auto_active_o)
      && $stable(frame_status_o))
    else $error("stalled result changed");

  // in auto mode relay one follows the gas alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && auto_active_o |-> relay_one_o == buzzer_o)
    else $error("relay one does not follow alarm in auto mode");

  // an applied frame only in manual mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == FS_APPLIED) |-> !auto_active_o)
    else $error("frame applied in auto mode");

  // an ignored frame only in auto mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == FS_IGNORED) |-> auto_active_o)
    else $error("frame ignored in manual mode");

endmodule

bind relay_controller_with_frame_rx_core rcfr_checker u_rcfr_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the relay controller with serial frame receiver
`default_nettype none

module tb_top;
  import rcfr_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 3;
  localparam int SETTLE_CYCLES  = 4;
  localparam int CYCLE_LIMIT    = 100000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PRESSURE_ITEMS = 40;
  localparam int PHASE_ITEMS    = 250;
  localparam int SEGMENTS       = 4;
  localparam int FRAME_BYTES    = LAST_POS + 1;
  localparam int LEVEL_MAX      = (1 << LEVEL_W) - 1;
  localparam int BYTE_MAX       = (1 << BYTE_W) - 1;

  // op codes the block has no action for
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef enum {FRM_GOOD, FRM_BAD_SUM, FRM_BAD_END, FRM_RESTART, FRM_TRUNCATED} frame_kind_e;
  typedef enum {PLAN_SPREAD, PLAN_FLOOR, PLAN_WIDE, PLAN_CROSSED, PLAN_DEFAULT} level_plan_e;
  localparam int PLAN_COUNT = 5;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      op = OP_SAMPLE;
  logic [LEVEL_W-1:0]   gas_level = '0;
  logic [LEVEL_W-1:0]   light_level = '0;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 relay_one, relay_two, buzzer, auto_active;
  logic [1:0]           frame_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GAS_ON;
  logic [LEVEL_W-1:0]   cfg_data = '0;

  // mirror of the controller state, starting from its reset values
  logic [POS_W-1:0]   frm_pos = '0;
  logic [BYTE_W-1:0]  frm_xor = '0;
  logic [1:0]         frm_relays = '0;
  logic [BYTE_W-1:0]  frm_check = '0;
  logic               alarm_q = 1'b0;
  logic               r1_q = 1'b0;
  logic               r2_q = 1'b0;
  logic               auto_q = 1'b1;
  logic [LEVEL_W-1:0] gas_q = '0;
  logic [LEVEL_W-1:0] light_q = '0;
  logic [LEVEL_W-1:0] lvl_gas_on = ON_LEVEL_RST;
  logic [LEVEL_W-1:0] lvl_gas_off = OFF_LEVEL_RST;
  logic [LEVEL_W-1:0] lvl_light_on = ON_LEVEL_RST;
  logic [LEVEL_W-1:0] lvl_light_off = OFF_LEVEL_RST;

  res_t drives_due[$];
  res_t head;
  int   errors = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   plan_no = 0;

  relay_controller_with_frame_rx_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .gas_level_i    (gas_level),
    .light_level_i  (light_level),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .relay_one_o    (relay_one),
    .relay_two_o    (relay_two),
    .buzzer_o       (buzzer),
    .auto_active_o  (auto_active),
    .frame_status_o (frame_status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drives_due.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        head = drives_due.pop_front();
        if (relay_one !== head.relay_one) begin
          $error("relay_one: expected %0d, actual %0d", head.relay_one, relay_one);
          errors++;
        end
        if (relay_two !== head.relay_two) begin
          $error("relay_two: expected %0d, actual %0d", head.relay_two, relay_two);
          errors++;
        end
        if (buzzer !== head.buzzer) begin
          $error("buzzer: expected %0d, actual %0d", head.buzzer, buzzer);
          errors++;
        end
        if (auto_active !== head.auto_active) begin
          $error("auto_active: expected %0d, actual %0d", head.auto_active, auto_active);
          errors++;
        end
        if (frame_status !== head.frame_status) begin
          $error("frame_status: expected %0d, actual %0d", head.frame_status, frame_status);
          errors++;
        end
      end
    end
  end

  // advances the mirrored state by one event and gives the drives it leaves
  function automatic res_t next_drives(input logic [OP_W-1:0] o, input logic [LEVEL_W-1:0] g,
                                       input logic [LEVEL_W-1:0] l, input logic [BYTE_W-1:0] b);
    res_t       d;
    logic [1:0] fs;
    fs = FS_NONE;
    case (o)
      OP_SAMPLE: begin
        gas_q = g;
        light_q = l;
      end
      OP_BYTE: begin
        if (b == FRAME_START) begin
          frm_pos = POS_W'(1);
          frm_xor = '0;
        end else if (frm_pos != 0) begin
          if (frm_pos <= PAYLOAD_LAST) frm_xor ^= b;
          if (frm_pos == RELAY_POS) frm_relays = b[1:0];
          if (frm_pos == CHECK_POS) frm_check = b;
          if (frm_pos >= LAST_POS) begin
            if (b == FRAME_END && frm_check == frm_xor) begin
              if (!auto_q) begin
                r1_q = frm_relays[0];
                r2_q = frm_relays[1];
                fs = FS_APPLIED;
              end else begin
                fs = FS_IGNORED;
              end
            end else begin
              fs = FS_BAD;
            end
            frm_pos = '0;
          end else begin
            frm_pos = frm_pos + POS_W'(1);
          end
        end
      end
      OP_MODE: auto_q = ~auto_q;
      OP_TOGGLE1: if (!auto_q) r1_q = ~r1_q;
      OP_TOGGLE2: if (!auto_q) r2_q = ~r2_q;
      default: ;
    endcase
    // the on test wins when the levels are crossed
    if (gas_q >= lvl_gas_on) alarm_q = 1'b1;
    else if (gas_q <= lvl_gas_off) alarm_q = 1'b0;
    if (auto_q) begin
      r1_q = alarm_q;
      if (light_q >= lvl_light_on) r2_q = 1'b1;
      else if (light_q <= lvl_light_off) r2_q = 1'b0;
    end
    d.relay_one = r1_q;
    d.relay_two = r2_q;
    d.buzzer = alarm_q;
    d.auto_active = auto_q;
    d.frame_status = fs;
    return d;
  endfunction

  function automatic logic [BYTE_W-1:0] other_byte(input logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(BYTE_MAX)); while (v == avoid);
    return v;
  endfunction

  // mostly readings close to a threshold, so hysteresis edges are hit
  function automatic logic [LEVEL_W-1:0] near_level(input logic [LEVEL_W-1:0] on_lvl,
                                                    input logic [LEVEL_W-1:0] off_lvl);
    int unsigned pick;
    int          v;
    pick = $urandom_range(9);
    if (pick < 4) return LEVEL_W'($urandom_range(LEVEL_MAX));
    v = (pick < 7) ? int'(on_lvl) : int'(off_lvl);
    v = v + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    return LEVEL_W'(v);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [LEVEL_W-1:0] g,
                           input logic [LEVEL_W-1:0] l, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    gas_level <= g;
    light_level <= l;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    drives_due.push_back(next_drives(o, g, l, b));
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] o);
    send_item(o, LEVEL_W'($urandom_range(LEVEL_MAX)), LEVEL_W'($urandom_range(LEVEL_MAX)),
              BYTE_W'($urandom_range(BYTE_MAX)));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_item(OP_BYTE, LEVEL_W'($urandom_range(LEVEL_MAX)),
              LEVEL_W'($urandom_range(LEVEL_MAX)), b);
  endtask

  task automatic send_sample(input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] l);
    send_item(OP_SAMPLE, g, l, BYTE_W'($urandom_range(BYTE_MAX)));
  endtask

  // lets every outstanding result drain before the block is touched
  task automatic settle();
    in_valid <= 1'b0;
    while (drives_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_GAS_ON:    lvl_gas_on = val;
      REG_GAS_OFF:   lvl_gas_off = val;
      REG_LIGHT_ON:  lvl_light_on = val;
      REG_LIGHT_OFF: lvl_light_off = val;
      default: ;
    endcase
  endtask

  task automatic program_levels(input logic [LEVEL_W-1:0] g_on, input logic [LEVEL_W-1:0] g_off,
                                input logic [LEVEL_W-1:0] l_on, input logic [LEVEL_W-1:0] l_off);
    settle();
    write_level(REG_GAS_ON, g_on);
    write_level(REG_GAS_OFF, g_off);
    write_level(REG_LIGHT_ON, l_on);
    write_level(REG_LIGHT_OFF, l_off);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic [BYTE_W-1:0] fb [FRAME_BYTES];
    logic [BYTE_W-1:0] chk;
    int                prefix;
    int                cut;
    fb[0] = FRAME_START;
    for (int i = 1; i < FRAME_BYTES; i++) fb[i] = other_byte(FRAME_START);
    // a checksum equal to the start byte would reopen the frame
    do begin
      chk = '0;
      for (int i = 1; i <= PAYLOAD_LAST; i++) chk ^= fb[i];
      if (chk == FRAME_START) fb[PAYLOAD_LAST] = other_byte(FRAME_START);
    end while (chk == FRAME_START);
    fb[CHECK_POS] = chk;
    fb[LAST_POS] = FRAME_END;
    prefix = 0;
    cut = LAST_POS;
    case (kind)
      FRM_BAD_SUM: begin
        do fb[CHECK_POS] = other_byte(FRAME_START); while (fb[CHECK_POS] == chk);
      end
      FRM_BAD_END: begin
        do fb[LAST_POS] = other_byte(FRAME_START); while (fb[LAST_POS] == FRAME_END);
      end
      FRM_RESTART: prefix = $urandom_range(LAST_POS, 1);
      FRM_TRUNCATED: cut = $urandom_range(CHECK_POS, 1);
      default: ;
    endcase
    // a start byte part way through begins the frame again
    for (int i = 0; i < prefix; i++) send_byte(fb[i]);
    for (int i = 0; i <= cut; i++) send_byte(fb[i]);
  endtask

  task automatic random_event();
    int unsigned r;
    frame_kind_e kind;
    r = $urandom_range(99);
    if (r < 30) begin
      r = $urandom_range(99);
      kind = (r < 60) ? FRM_GOOD : (r < 70) ? FRM_BAD_SUM : (r < 80) ? FRM_BAD_END :
             (r < 90) ? FRM_RESTART : FRM_TRUNCATED;
      send_frame(kind);
    end else if (r < 55) begin
      send_sample(near_level(lvl_gas_on, lvl_gas_off), near_level(lvl_light_on, lvl_light_off));
    end else if (r < 65) begin
      send_op(OP_MODE);
    end else if (r < 73) begin
      send_op(OP_TOGGLE1);
    end else if (r < 81) begin
      send_op(OP_TOGGLE2);
    end else if (r < 91) begin
      send_byte(BYTE_W'($urandom_range(BYTE_MAX)));
    end else begin
      send_op(OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)));
    end
  endtask

  task automatic test_reset_and_extremes();
    send_sample('0, '0);
    send_sample(LEVEL_W'(LEVEL_MAX), LEVEL_W'(LEVEL_MAX));
    send_sample(LEVEL_W'(OFF_LEVEL_RST + 1), LEVEL_W'(OFF_LEVEL_RST + 1));
    send_sample(OFF_LEVEL_RST, OFF_LEVEL_RST);
    send_sample(LEVEL_W'(ON_LEVEL_RST - 1), LEVEL_W'(ON_LEVEL_RST - 1));
    send_sample(ON_LEVEL_RST, ON_LEVEL_RST);
    // manual toggles are ignored in auto mode
    send_op(OP_TOGGLE1);
    send_op(OP_TOGGLE2);
    // bytes with no frame open
    send_byte(FRAME_END);
    send_byte('0);
    send_byte(BYTE_W'(BYTE_MAX));
    send_op(OP_UNUSED_FIRST);
    send_op(OP_UNUSED_LAST);
    send_op(OP_MODE);
    send_op(OP_TOGGLE1);
    send_op(OP_TOGGLE2);
    send_op(OP_TOGGLE1);
    send_sample('0, LEVEL_W'(LEVEL_MAX));
    send_sample(LEVEL_W'(LEVEL_MAX), '0);
    send_op(OP_UNUSED_FIRST);
    send_op(OP_MODE);
    send_sample('0, '0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
    logic [LEVEL_W-1:0] g_on, g_off, l_on, l_off;
    level_plan_e        plan;
    int                 goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int s = 0; s < SEGMENTS; s++) begin
      plan = level_plan_e'(plan_no % PLAN_COUNT);
      plan_no++;
      case (plan)
        PLAN_SPREAD: begin
          g_off = LEVEL_W'($urandom_range(4000));
          g_on = g_off + LEVEL_W'($urandom_range(95, 1));
          l_off = LEVEL_W'($urandom_range(4000));
          l_on = l_off + LEVEL_W'($urandom_range(95, 1));
        end
        PLAN_FLOOR: begin
          g_on = '0;
          g_off = '0;
          l_on = LEVEL_W'(LEVEL_MAX);
          l_off = LEVEL_W'(LEVEL_MAX);
        end
        PLAN_WIDE: begin
          g_on = LEVEL_W'(LEVEL_MAX);
          g_off = '0;
          l_on = '0;
          l_off = LEVEL_W'(LEVEL_MAX);
        end
        PLAN_CROSSED: begin
          g_on = LEVEL_W'($urandom_range(3000));
          g_off = g_on + LEVEL_W'($urandom_range(1000, 1));
          l_on = LEVEL_W'($urandom_range(3000));
          l_off = l_on + LEVEL_W'($urandom_range(1000, 1));
        end
        default: begin
          g_on = ON_LEVEL_RST;
          g_off = OFF_LEVEL_RST;
          l_on = ON_LEVEL_RST;
          l_off = OFF_LEVEL_RST;
        end
      endcase
      program_levels(g_on, g_off, l_on, l_off);
      goal = items_sent + n / SEGMENTS;
      while (items_sent < goal) random_event();
    end
  endtask

  // receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    int goal;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs++;
    goal = items_sent + PRESSURE_ITEMS;
    while (items_sent < goal) random_event();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_extremes();
    test_random_traffic(29, 45, PHASE_ITEMS);
    test_random_traffic(45, 29, PHASE_ITEMS);
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_backpressure();
    recv_idle_pct = 0;
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/rcfr_pkg.sv
hw/rtl/rcfr_frame_rx.sv
hw/rtl/rcfr_ctrl.sv
hw/rtl/relay_controller_with_frame_rx_core.sv
hw/rtl/rcfr_checker.sv
tb/tb_top.sv
